// ----- rtl/spba_pkg.sv -----
// Package for the segregated pool block allocator.
// Holds defaults, operation and status codes, register indexes and helpers.
// Depends on nothing.
package spba_pkg;

  localparam int unsigned DEFAULT_HEADER_BYTES = 8;
  localparam int unsigned DEFAULT_SMALL_COUNT  = 8;
  localparam int unsigned DEFAULT_MIDDLE_COUNT = 8;
  localparam int unsigned DEFAULT_LARGE_COUNT  = 4;

  localparam int unsigned NUM_POOLS = 3;

  localparam logic [3:0] LOG2_MIN = 4'd4;
  localparam logic [3:0] LOG2_MAX = 4'd12;

  localparam logic [3:0]  RESET_SMALL_LOG2  = 4'd4;
  localparam logic [3:0]  RESET_MIDDLE_LOG2 = 4'd5;
  localparam logic [3:0]  RESET_LARGE_LOG2  = 4'd6;
  localparam logic [31:0] RESET_AREA_BASE   = 32'd0;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT   = 2'd1;
  localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;

  localparam logic [1:0] POOL_SMALL  = 2'd0;
  localparam logic [1:0] POOL_MIDDLE = 2'd1;
  localparam logic [1:0] POOL_LARGE  = 2'd2;

  localparam logic [1:0] REG_AREA_BASE   = 2'd0;
  localparam logic [1:0] REG_SMALL_LOG2  = 2'd1;
  localparam logic [1:0] REG_MIDDLE_LOG2 = 2'd2;
  localparam logic [1:0] REG_LARGE_LOG2  = 2'd3;

  typedef struct packed {
    logic [1:0] pool;
    logic [1:0] status;
  } dec_t;

  function automatic logic [3:0] clamp_log2(input logic [3:0] v);
    logic [3:0] r;
    r = v;
    if (v < LOG2_MIN) r = LOG2_MIN;
    if (v > LOG2_MAX) r = LOG2_MAX;
    return r;
  endfunction

endpackage

// ----- rtl/spba_link_ram.sv -----
// Link memory of all three free lists, one entry per block.
// Registered synchronous read plus per-entry written flags.
// Depends on nothing.
module spba_link_ram #(
  parameter int unsigned DEPTH = 20,
  parameter int unsigned AW    = 5,
  parameter int unsigned LW    = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [LW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [LW-1:0] rdata_o,
  output logic          rwritten_o
);

  logic [LW-1:0] mem [DEPTH];
  logic [DEPTH-1:0] written_q;
  logic [LW-1:0] rdata_q;
  logic          rwritten_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q  <= '0;
      rwritten_q <= 1'b0;
    end else begin
      if (we_i) begin
        written_q[waddr_i] <= 1'b1;
      end
      rwritten_q <= written_q[raddr_i];
    end
  end

  assign rdata_o    = rdata_q;
  assign rwritten_o = rwritten_q;

endmodule

// ----- rtl/spba_decode.sv -----
// Request decode: picks the serving pool of an allocate, or the pool and
// block of a free. Uses spba_pkg for codes and the decision type.
module spba_decode #(
  parameter int unsigned SMALL_COUNT  = spba_pkg::DEFAULT_SMALL_COUNT,
  parameter int unsigned MIDDLE_COUNT = spba_pkg::DEFAULT_MIDDLE_COUNT,
  parameter int unsigned LARGE_COUNT  = spba_pkg::DEFAULT_LARGE_COUNT,
  parameter int unsigned HEADER_BYTES = spba_pkg::DEFAULT_HEADER_BYTES,
  parameter int unsigned LW           = 4
) (
  input  logic                kind_i,
  input  logic [15:0]         request_bytes_i,
  input  logic [31:0]         block_address_i,
  input  logic [3:0]          lg_i   [spba_pkg::NUM_POOLS],
  input  logic [31:0]         adj_i  [spba_pkg::NUM_POOLS],
  input  logic [LW-1:0]       head_i [spba_pkg::NUM_POOLS],
  output spba_pkg::dec_t      dec_o,
  output logic [LW-1:0]       blk_o
);

  localparam int unsigned CNT [spba_pkg::NUM_POOLS] =
    '{SMALL_COUNT, MIDDLE_COUNT, LARGE_COUNT};

  logic [16:0]   cap   [spba_pkg::NUM_POOLS];
  logic [31:0]   off   [spba_pkg::NUM_POOLS];
  logic [31:0]   span  [spba_pkg::NUM_POOLS];
  logic [31:0]   mask  [spba_pkg::NUM_POOLS];
  logic [LW-1:0] fblk  [spba_pkg::NUM_POOLS];
  logic [spba_pkg::NUM_POOLS-1:0] fits;
  logic [spba_pkg::NUM_POOLS-1:0] hit;

  always_comb begin
    for (int p = 0; p < spba_pkg::NUM_POOLS; p++) begin
      cap[p]  = (17'(1) << lg_i[p]) - 17'(HEADER_BYTES);
      fits[p] = (head_i[p] < LW'(CNT[p])) && ({1'b0, request_bytes_i} <= cap[p]);
      off[p]  = block_address_i - adj_i[p];
      span[p] = 32'(CNT[p]) << lg_i[p];
      mask[p] = (32'(1) << lg_i[p]) - 32'(1);
      hit[p]  = (off[p] < span[p]) && ((off[p] & mask[p]) == 32'd0);
      fblk[p] = LW'(off[p] >> lg_i[p]);
    end
  end

  always_comb begin
    dec_o.pool   = spba_pkg::POOL_SMALL;
    dec_o.status = spba_pkg::STATUS_OK;
    blk_o        = '0;
    if (kind_i == spba_pkg::KIND_ALLOC) begin
      if (fits[0]) begin
        dec_o.pool = spba_pkg::POOL_SMALL;
        blk_o      = head_i[0];
      end else if (fits[1]) begin
        dec_o.pool = spba_pkg::POOL_MIDDLE;
        blk_o      = head_i[1];
      end else if (fits[2]) begin
        dec_o.pool = spba_pkg::POOL_LARGE;
        blk_o      = head_i[2];
      end else begin
        dec_o.status = spba_pkg::STATUS_NO_FIT;
      end
    end else begin
      if (hit[0]) begin
        dec_o.pool = spba_pkg::POOL_SMALL;
        blk_o      = fblk[0];
      end else if (hit[1]) begin
        dec_o.pool = spba_pkg::POOL_MIDDLE;
        blk_o      = fblk[1];
      end else if (hit[2]) begin
        dec_o.pool = spba_pkg::POOL_LARGE;
        blk_o      = fblk[2];
      end else begin
        dec_o.status = spba_pkg::STATUS_BAD_ADDR;
      end
    end
  end

endmodule

// ----- rtl/segregated_pool_block_allocator_top.sv -----
// Top level of the segregated pool block allocator: config registers, list
// heads, sequencer and result register. Uses spba_pkg, spba_decode and
// spba_link_ram.
//
//   channel   handshake                        payload
//   request   start / busy                     kind_i, request_bytes_i, block_address_i
//   result    done_o (one-cycle strobe)        granted_address_o, pool_used_o, status_o
//   config    psel/penable/pwrite, pready=1    paddr, pwdata, prdata
//
// An item goes through accept, decode with link read, and commit of head and link.
// The link read issued in decode returns in commit from the registered link memory.
// busy drops in the same cycle as the result strobe unless a config write is settling.
// After reset and after each config write, busy stays high while the pool base
// addresses are recomputed. The receiver cannot stall results.
module segregated_pool_block_allocator_top #(
  parameter int unsigned HEADER_BYTES = spba_pkg::DEFAULT_HEADER_BYTES,
  parameter int unsigned SMALL_COUNT  = spba_pkg::DEFAULT_SMALL_COUNT,
  parameter int unsigned MIDDLE_COUNT = spba_pkg::DEFAULT_MIDDLE_COUNT,
  parameter int unsigned LARGE_COUNT  = spba_pkg::DEFAULT_LARGE_COUNT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        kind_i,
  input  logic [15:0] request_bytes_i,
  input  logic [31:0] block_address_i,
  output logic        done_o,
  output logic [31:0] granted_address_o,
  output logic [1:0]  pool_used_o,
  output logic [1:0]  status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned MAX_COUNT =
    (SMALL_COUNT > MIDDLE_COUNT)
      ? ((SMALL_COUNT > LARGE_COUNT) ? SMALL_COUNT : LARGE_COUNT)
      : ((MIDDLE_COUNT > LARGE_COUNT) ? MIDDLE_COUNT : LARGE_COUNT);
  localparam int unsigned LW    = $clog2(MAX_COUNT + 1);
  localparam int unsigned TOTAL = SMALL_COUNT + MIDDLE_COUNT + LARGE_COUNT;
  localparam int unsigned AW    = $clog2(TOTAL);
  localparam int unsigned OFF [spba_pkg::NUM_POOLS] =
    '{0, SMALL_COUNT, SMALL_COUNT + MIDDLE_COUNT};
  localparam logic [1:0] SETTLE = 2'd2;

  typedef enum logic [1:0] {ST_IDLE, ST_DECODE, ST_COMMIT} state_e;

  state_e state_q;
  logic   done_q;
  logic [31:0] granted_q;
  logic [1:0]  pool_used_q;
  logic [1:0]  status_q;

  logic [31:0] area_base_q;
  logic [3:0]  log2_q [spba_pkg::NUM_POOLS];
  logic [3:0]  lg     [spba_pkg::NUM_POOLS];
  logic [31:0] adj_q  [spba_pkg::NUM_POOLS];
  logic [1:0]  settle_q;
  logic        cfg_wr;

  logic [LW-1:0] head_q [spba_pkg::NUM_POOLS];

  logic          kind_q;
  logic [15:0]   req_q;
  logic [31:0]   addr_q;
  spba_pkg::dec_t dec, dec_q;
  logic [LW-1:0] blk, blk_q;

  logic          accept;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [LW-1:0] mem_rdata;
  logic          mem_written;
  logic [LW-1:0] link;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign busy   = (state_q != ST_IDLE) || (settle_q != 2'd0);
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_base_q <= spba_pkg::RESET_AREA_BASE;
      log2_q[0]   <= spba_pkg::RESET_SMALL_LOG2;
      log2_q[1]   <= spba_pkg::RESET_MIDDLE_LOG2;
      log2_q[2]   <= spba_pkg::RESET_LARGE_LOG2;
      settle_q    <= SETTLE;
    end else begin
      if (cfg_wr) begin
        settle_q <= SETTLE;
        unique case (paddr[3:2])
          spba_pkg::REG_AREA_BASE:   area_base_q <= pwdata;
          spba_pkg::REG_SMALL_LOG2:  log2_q[0]   <= pwdata[3:0];
          spba_pkg::REG_MIDDLE_LOG2: log2_q[1]   <= pwdata[3:0];
          spba_pkg::REG_LARGE_LOG2:  log2_q[2]   <= pwdata[3:0];
          default: ;
        endcase
      end else if (settle_q != 2'd0) begin
        settle_q <= settle_q - 2'd1;
      end
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      spba_pkg::REG_AREA_BASE:   prdata = area_base_q;
      spba_pkg::REG_SMALL_LOG2:  prdata = {28'd0, log2_q[0]};
      spba_pkg::REG_MIDDLE_LOG2: prdata = {28'd0, log2_q[1]};
      spba_pkg::REG_LARGE_LOG2:  prdata = {28'd0, log2_q[2]};
      default:                   prdata = 32'd0;
    endcase
  end

  always_comb begin
    for (int p = 0; p < spba_pkg::NUM_POOLS; p++) begin
      lg[p] = spba_pkg::clamp_log2(log2_q[p]);
    end
  end

  // Block start plus header of block 0 in each pool.
  always_ff @(posedge clk_i) begin
    adj_q[0] <= area_base_q + 32'(HEADER_BYTES);
    adj_q[1] <= adj_q[0] + (32'(SMALL_COUNT) << lg[0]);
    adj_q[2] <= adj_q[1] + (32'(MIDDLE_COUNT) << lg[1]);
  end

  spba_decode #(
    .SMALL_COUNT  (SMALL_COUNT),
    .MIDDLE_COUNT (MIDDLE_COUNT),
    .LARGE_COUNT  (LARGE_COUNT),
    .HEADER_BYTES (HEADER_BYTES),
    .LW           (LW)
  ) u_decode (
    .kind_i          (kind_q),
    .request_bytes_i (req_q),
    .block_address_i (addr_q),
    .lg_i            (lg),
    .adj_i           (adj_q),
    .head_i          (head_q),
    .dec_o           (dec),
    .blk_o           (blk)
  );

  assign mem_raddr = AW'(OFF[dec.pool]) + AW'(blk);
  assign mem_waddr = AW'(OFF[dec_q.pool]) + AW'(blk_q);
  assign mem_we    = (state_q == ST_COMMIT) && (kind_q == spba_pkg::KIND_FREE) &&
                     (dec_q.status == spba_pkg::STATUS_OK);

  spba_link_ram #(
    .DEPTH (TOTAL),
    .AW    (AW),
    .LW    (LW)
  ) u_links (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (mem_we),
    .waddr_i    (mem_waddr),
    .wdata_i    (head_q[dec_q.pool]),
    .raddr_i    (mem_raddr),
    .rdata_o    (mem_rdata),
    .rwritten_o (mem_written)
  );

  // An unwritten link still holds its reset chain value: next block, or none.
  assign link = mem_written ? mem_rdata : blk_q + LW'(1);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      req_q  <= request_bytes_i;
      addr_q <= block_address_i;
    end
    if (state_q == ST_DECODE) begin
      dec_q <= dec;
      blk_q <= blk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < spba_pkg::NUM_POOLS; p++) begin
        head_q[p] <= '0;
      end
    end else if ((state_q == ST_COMMIT) && (dec_q.status == spba_pkg::STATUS_OK)) begin
      head_q[dec_q.pool] <= (kind_q == spba_pkg::KIND_ALLOC) ? link : blk_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      done_q      <= 1'b0;
      granted_q   <= 32'd0;
      pool_used_q <= spba_pkg::POOL_SMALL;
      status_q    <= spba_pkg::STATUS_OK;
    end else begin
      done_q <= (state_q == ST_COMMIT);
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          state_q <= ST_COMMIT;
        end
        ST_COMMIT: begin
          state_q  <= ST_IDLE;
          status_q <= dec_q.status;
          if (dec_q.status == spba_pkg::STATUS_OK) begin
            pool_used_q <= dec_q.pool;
            granted_q   <= (kind_q == spba_pkg::KIND_ALLOC)
                           ? adj_q[dec_q.pool] + (32'(blk_q) << lg[dec_q.pool])
                           : 32'd0;
          end else begin
            pool_used_q <= spba_pkg::POOL_SMALL;
            granted_q   <= 32'd0;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o            = done_q;
  assign granted_address_o = granted_q;
  assign pool_used_o       = pool_used_q;
  assign status_o          = status_q;

endmodule

// ----- rtl/spba_checker.sv -----
// Port-level checks for the segregated pool block allocator, bound to the top.
// Uses spba_pkg for status and pool codes.
module spba_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [31:0] granted_address_o,
  input logic [1:0]  pool_used_o,
  input logic [1:0]  status_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  a_no_early_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !done_o)
    else $error("result beat right after accept");

  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##3 done_o)
    else $error("result beat missing three cycles after accept");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != spba_pkg::STATUS_OK) |->
      (granted_address_o == 32'd0) && (pool_used_o == spba_pkg::POOL_SMALL))
    else $error("error beat carries address or pool");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == spba_pkg::STATUS_OK) || (status_o == spba_pkg::STATUS_NO_FIT) ||
               (status_o == spba_pkg::STATUS_BAD_ADDR))
    else $error("undefined status on result beat");

endmodule

bind segregated_pool_block_allocator_top spba_checker u_spba_checker (.*);

// ----- bench/tb_segregated_pool_block_allocator_top.sv -----
// Self-checking bench for segregated_pool_block_allocator_top: drives requests over
// start/busy and register writes over APB, and checks each result against a free-list tracker.
// Depends on spba_pkg and the RTL top level only.
module tb_segregated_pool_block_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spba_pkg::*;

  localparam int unsigned HDR = DEFAULT_HEADER_BYTES;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 204;

  typedef struct packed {
    logic [31:0] granted;
    logic [1:0]  pool;
    logic [1:0]  status;
  } grant_t;

  typedef struct packed {
    logic [1:0] pool;
    logic [7:0] blk;
  } block_ref_t;

  class free_list_tracker;
    logic [31:0] area_base;
    logic [3:0]  log2_reg [3];
    int          count [3];
    int          head [3];
    int          links [3][64];
    grant_t      pending_grants[$];
    block_ref_t  live_q[$];
    block_ref_t  freed_q[$];
    int          mismatches, checked, allocs, frees, no_fits, bad_addrs, settings;

    function new();
      count[0] = DEFAULT_SMALL_COUNT;
      count[1] = DEFAULT_MIDDLE_COUNT;
      count[2] = DEFAULT_LARGE_COUNT;
      area_base = RESET_AREA_BASE;
      log2_reg[0] = RESET_SMALL_LOG2;
      log2_reg[1] = RESET_MIDDLE_LOG2;
      log2_reg[2] = RESET_LARGE_LOG2;
      for (int p = 0; p < NUM_POOLS; p++) begin
        head[p] = 0;
        for (int i = 0; i < count[p]; i++) links[p][i] = i + 1;
      end
      settings = 1;
    endfunction

    function int block_log2(int p);
      int v;
      v = log2_reg[p];
      if (v < int'(LOG2_MIN)) v = LOG2_MIN;
      if (v > int'(LOG2_MAX)) v = LOG2_MAX;
      return v;
    endfunction

    function logic [31:0] pool_start(int p);
      logic [31:0] b;
      b = area_base;
      for (int k = 0; k < p; k++) b += 32'(count[k]) << block_log2(k);
      return b;
    endfunction

    function logic [31:0] block_addr(int p, int blk);
      return pool_start(p) + (32'(blk) << block_log2(p)) + 32'(HDR);
    endfunction

    function void write_register(logic [1:0] idx, logic [31:0] v);
      case (idx)
        REG_AREA_BASE:   area_base = v;
        REG_SMALL_LOG2:  log2_reg[0] = v[3:0];
        REG_MIDDLE_LOG2: log2_reg[1] = v[3:0];
        REG_LARGE_LOG2:  log2_reg[2] = v[3:0];
        default: ;
      endcase
    endfunction

    function void retire_block(int p, int blk);
      int idx;
      idx = -1;
      for (int i = 0; i < live_q.size() && idx < 0; i++)
        if (live_q[i].pool == 2'(p) && live_q[i].blk == 8'(blk)) idx = i;
      if (idx >= 0) live_q.delete(idx);
      freed_q.push_back('{pool: 2'(p), blk: 8'(blk)});
      if (freed_q.size() > 16) void'(freed_q.pop_front());
    endfunction

    function void apply_request(logic kind, logic [15:0] req, logic [31:0] addr);
      grant_t      g;
      logic [31:0] off, span;
      int          lg, blk;
      bit          found;
      g = '0;
      found = 0;
      if (kind == KIND_ALLOC) begin
        allocs++;
        for (int p = 0; p < NUM_POOLS && !found; p++) begin
          lg = block_log2(p);
          if (head[p] < count[p] && int'(req) <= (1 << lg) - int'(HDR)) begin
            blk = head[p];
            head[p] = links[p][blk];
            g.granted = block_addr(p, blk);
            g.pool = 2'(p);
            g.status = STATUS_OK;
            found = 1;
            live_q.push_back('{pool: 2'(p), blk: 8'(blk)});
          end
        end
        if (!found) begin
          g.status = STATUS_NO_FIT;
          no_fits++;
        end
      end else begin
        frees++;
        for (int p = 0; p < NUM_POOLS && !found; p++) begin
          lg = block_log2(p);
          off = addr - 32'(HDR) - pool_start(p);
          span = 32'(count[p]) << lg;
          if (off < span && (off & ((32'd1 << lg) - 32'd1)) == 32'd0) begin
            blk = int'(off >> lg);
            links[p][blk] = head[p];
            head[p] = blk;
            g.pool = 2'(p);
            g.status = STATUS_OK;
            found = 1;
            retire_block(p, blk);
          end
        end
        if (!found) begin
          g.status = STATUS_BAD_ADDR;
          bad_addrs++;
        end
      end
      pending_grants.push_back(g);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void check_grant(grant_t got);
      grant_t want;
      if (pending_grants.size() == 0) begin
        flag($sformatf("result with none expected: addr %h pool %0d status %0d",
                       got.granted, got.pool, got.status));
        return;
      end
      want = pending_grants.pop_front();
      checked++;
      if (got.granted !== want.granted)
        flag($sformatf("granted_address: expected %h, got %h", want.granted, got.granted));
      if (got.pool !== want.pool)
        flag($sformatf("pool_used: expected %0d, got %0d", want.pool, got.pool));
      if (got.status !== want.status)
        flag($sformatf("status: expected %0d, got %0d", want.status, got.status));
    endfunction

    function int grants_waiting();
      return pending_grants.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        kind_i = KIND_ALLOC;
  logic [15:0] request_bytes_i = '0;
  logic [31:0] block_address_i = '0;
  logic        done_o;
  logic [31:0] granted_address_o;
  logic [1:0]  pool_used_o;
  logic [1:0]  status_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int               stall_cycles = 0;
  free_list_tracker tracker = new();

  segregated_pool_block_allocator_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .kind_i            (kind_i),
    .request_bytes_i   (request_bytes_i),
    .block_address_i   (block_address_i),
    .done_o            (done_o),
    .granted_address_o (granted_address_o),
    .pool_used_o       (pool_used_o),
    .status_o          (status_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1)
      tracker.check_grant('{granted: granted_address_o, pool: pool_used_o, status: status_o});
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && busy === 1'b0) || done_o === 1'b1 || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_segregated_pool_block_allocator_top failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_beat(logic k, logic [15:0] rq, logic [31:0] ad);
    @(negedge clk_i);
    start <= 1'b1;
    kind_i <= k;
    request_bytes_i <= rq;
    block_address_i <= ad;
    do @(posedge clk_i); while (busy !== 1'b0);
    tracker.apply_request(k, rq, ad);
  endtask

  task automatic hold_sender(int pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  task automatic drain;
    while (tracker.grants_waiting() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    logic [31:0] got, mask;
    mask = (idx == REG_AREA_BASE) ? 32'hFFFF_FFFF : 32'h0000_000F;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    tracker.write_register(idx, v);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    got = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if ((got & mask) !== (v & mask))
      tracker.flag($sformatf("readback of register %0d: expected %h, got %h",
                             idx, v & mask, got & mask));
  endtask

  task automatic make_request(output logic k, output logic [15:0] rq, output logic [31:0] ad);
    int         sel, pool, cap, live_n, freed_n;
    block_ref_t b;
    live_n = tracker.live_q.size();
    freed_n = tracker.freed_q.size();
    sel = $urandom_range(99);
    k = (sel < (live_n < 4 ? 75 : (live_n > 14 ? 30 : 50))) ? KIND_ALLOC : KIND_FREE;
    rq = 16'($urandom);
    ad = $urandom;
    sel = $urandom_range(99);
    pool = $urandom_range(2);
    if (k == KIND_ALLOC) begin
      cap = (1 << tracker.block_log2(pool)) - int'(HDR);
      if (sel < 70) rq = 16'($urandom_range(0, cap));
      else if (sel < 85) rq = 16'(cap + $urandom_range(0, 1));
      else if (sel < 90) rq = 16'd0;
    end else if (sel < 65 && live_n > 0) begin
      b = tracker.live_q[$urandom_range(0, live_n - 1)];
      ad = tracker.block_addr(b.pool, b.blk);
    end else if (sel < 75 && freed_n > 0) begin
      b = tracker.freed_q[$urandom_range(0, freed_n - 1)];
      ad = tracker.block_addr(b.pool, b.blk);
    end else if (sel < 90) begin
      ad = tracker.block_addr(pool, $urandom_range(0, tracker.count[pool]))
           - 32'(HDR) * $urandom_range(0, 1) + 32'($urandom_range(0, 1));
    end
  endtask

  task automatic run_directed;
    send_beat(KIND_ALLOC, 16'd0, 32'hFFFF_FFFF);
    send_beat(KIND_ALLOC, 16'd8, 32'h0);
    send_beat(KIND_ALLOC, 16'd9, 32'h0);
    send_beat(KIND_ALLOC, 16'd24, 32'h0);
    send_beat(KIND_ALLOC, 16'd25, 32'h0);
    send_beat(KIND_ALLOC, 16'd56, 32'h0);
    send_beat(KIND_ALLOC, 16'd57, 32'h0);
    send_beat(KIND_ALLOC, 16'hFFFF, 32'h0);
    send_beat(KIND_FREE, 16'hFFFF, tracker.block_addr(POOL_SMALL, 0));
    send_beat(KIND_FREE, 16'h0, tracker.block_addr(POOL_SMALL, 0));
    send_beat(KIND_ALLOC, 16'd1, 32'h0);
    send_beat(KIND_ALLOC, 16'd1, 32'h0);
    send_beat(KIND_FREE, 16'h0, 32'h0);
    send_beat(KIND_FREE, 16'h0, 32'hFFFF_FFFF);
    send_beat(KIND_FREE, 16'h0, tracker.block_addr(POOL_MIDDLE, 0) + 32'd1);
    send_beat(KIND_FREE, 16'h0, tracker.block_addr(POOL_LARGE, 0) - 32'(HDR));
    send_beat(KIND_FREE, 16'h0, tracker.block_addr(POOL_MIDDLE, 0));
    send_beat(KIND_FREE, 16'h0, tracker.block_addr(POOL_LARGE, DEFAULT_LARGE_COUNT));
    repeat (4) send_beat(KIND_ALLOC, 16'd40, 32'h0);
    send_beat(KIND_FREE, 16'h0, tracker.block_addr(POOL_LARGE, 3));
    send_beat(KIND_ALLOC, 16'd40, 32'h0);
  endtask

  initial begin
    logic [31:0] base_set [PHASES];
    logic [3:0]  small_set [PHASES];
    logic [3:0]  middle_set [PHASES];
    logic [3:0]  large_set [PHASES];
    logic        k;
    logic [15:0] rq;
    logic [31:0] ad;
    int          idle_pct;

    base_set   = '{32'h0, 32'h0000_1000, 32'hFFFF_F000, 32'h8000_0004,
                   $urandom, 32'hFFFF_FFFF, 32'h0};
    small_set  = '{4'd4, 4'd4, 4'd12, 4'd0, 4'($urandom), 4'd13, 4'd6};
    middle_set = '{4'd5, 4'd4, 4'd12, 4'd15, 4'($urandom), 4'd5, 4'd5};
    large_set  = '{4'd6, 4'd4, 4'd12, 4'd3, 4'($urandom), 4'd14, 4'd4};

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        write_reg(REG_AREA_BASE, base_set[ph]);
        write_reg(REG_SMALL_LOG2, ($urandom & 32'hFFFF_FFF0) | 32'(small_set[ph]));
        write_reg(REG_MIDDLE_LOG2, ($urandom & 32'hFFFF_FFF0) | 32'(middle_set[ph]));
        write_reg(REG_LARGE_LOG2, ($urandom & 32'hFFFF_FFF0) | 32'(large_set[ph]));
        tracker.settings++;
      end
      idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 87 : 30);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        hold_sender(idle_pct);
        make_request(k, rq, ad);
        send_beat(k, rq, ad);
      end
      @(negedge clk_i);
      start <= 1'b0;
    end

    drain();
    repeat (6) @(posedge clk_i);
    $display("covered %0d allocations (%0d with no fitting block) and %0d frees (%0d to no block)",
             tracker.allocs, tracker.no_fits, tracker.frees, tracker.bad_addrs);
    $display("over %0d register settings; %0d results checked, %0d mismatches",
             tracker.settings, tracker.checked, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.grants_waiting() == 0) begin
      $display("tb_segregated_pool_block_allocator_top passed");
    end else begin
      $display("tb_segregated_pool_block_allocator_top failed");
    end
    $finish;
  end

endmodule
